// ===== rtl/iphp_pkg.sv =====
// ----------------------------------------------------------------------------
// iphp_pkg
// Types and constants shared by the IPv4 header parser front end, queue and
// verdict back end.
// ----------------------------------------------------------------------------
package iphp_pkg;

   typedef enum logic [1:0] {
      VerdictPassRaw       = 2'd0,
      VerdictPassValid     = 2'd1,
      VerdictDropMalformed = 2'd2,
      VerdictDropFragment  = 2'd3
   } verdict_type;

   typedef enum logic [1:0] {
      CsrTcpCheck  = 2'd0,
      CsrUdpCheck  = 2'd1,
      CsrFragDrop  = 2'd2,
      CsrUnused    = 2'd3
   } csr_index_type;

   localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [7:0]  ProtoUdp      = 8'd17;
   localparam logic [7:0]  ProtoIcmp     = 8'd1;
   localparam logic [15:0] EthHdrBytes   = 16'd14;
   localparam logic [15:0] IpMinEnd      = 16'd34;
   localparam logic [3:0]  IhlMin        = 4'd5;
   localparam logic [3:0]  IpVersion4    = 4'd4;
   localparam logic [15:0] L4CaptureSpan = 16'd14;
   localparam logic [13:0] FragMask      = 14'h3FFF;
   localparam logic [15:0] PosMax        = 16'hFFFF;

   // Frame state handed from the front end to the back end at the last byte.
   typedef struct packed {
      logic [15:0] frame_length;
      logic [15:0] ether_type;
      logic [7:0]  version_ihl;
      logic [15:0] ip_total_length;
      logic [15:0] fragment_word;
      logic [7:0]  time_to_live;
      logic [7:0]  protocol;
      logic [31:0] source;
      logic [31:0] dest;
      logic [31:0] ports;
      logic [15:0] l4_word;
   } frame_snap_type;

   typedef struct packed {
      logic           valid;
      frame_snap_type snap;
   } snap_xfer_type;

endpackage

// ===== rtl/iphp_ifs.sv =====
// ----------------------------------------------------------------------------
// iphp channel interfaces
// Byte input, verdict output and register write channels.
// ----------------------------------------------------------------------------
interface iphp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface iphp_rsp_if;
   import iphp_pkg::*;
   logic        valid;
   logic        ready;
   verdict_type verdict;
   logic [31:0] source_address;
   logic [31:0] dest_address;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [7:0]  protocol_number;
   logic [7:0]  tcp_flag_bits;
   logic [15:0] payload_length;
   logic [15:0] frame_length;

   modport source (output valid, output verdict, output source_address,
      output dest_address, output source_port, output dest_port,
      output protocol_number, output tcp_flag_bits, output payload_length,
      output frame_length, input ready);
   modport sink (input valid, input verdict, input source_address,
      input dest_address, input source_port, input dest_port,
      input protocol_number, input tcp_flag_bits, input payload_length,
      input frame_length, output ready);
endinterface

interface iphp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ipv4_header_parse_validate_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_parse_validate_core
// Ethernet/IPv4 header parser with TCP/UDP/fragment checks.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle on req_chan with no gaps required and returns
// one verdict transfer on rsp_chan per frame, through the queue slot and then
// the result register. The front end captures header fields as bytes pass;
// on the last byte its snapshot enters a QueueDepth-entry queue, and the back
// end turns the head entry into a registered result. Input stalls only while
// the queue is full, so with rsp_chan ready the block runs at one byte per
// cycle, including back-to-back one-byte frames. Register writes on csr_chan
// are accepted every cycle and should be made while no frame is in flight.
// ----------------------------------------------------------------------------
module ipv4_header_parse_validate_core #(
   parameter int QueueDepth = 2
) (
   input  logic        clock,
   input  logic        reset,
   iphp_req_if.sink    req_chan,
   iphp_rsp_if.source  rsp_chan,
   iphp_csr_if.sink    csr_chan
);
   import iphp_pkg::*;

   snap_xfer_type push;
   snap_xfer_type head;
   logic          q_full;
   logic          pop;

   iphp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   iphp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   iphp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

// ===== rtl/iphp_front.sv =====
// ----------------------------------------------------------------------------
// iphp_front
// Per-byte capture: position counter and header field registers. Hands a
// snapshot of the frame to the queue on the last byte and starts over.
// ----------------------------------------------------------------------------
module iphp_front (
   input  logic                    clock,
   input  logic                    reset,
   iphp_req_if.sink                req_chan,
   input  logic                    q_full,
   output iphp_pkg::snap_xfer_type push
);
   import iphp_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] ether_type_ff, ether_type_in;
   logic [7:0]  version_ihl_ff, version_ihl_in;
   logic [15:0] total_len_ff, total_len_in;
   logic [15:0] frag_ff, frag_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] ports_ff, ports_in;
   logic [15:0] l4_word_ff, l4_word_in;

   logic        accept;
   logic [7:0]  b;
   logic [3:0]  ihl;
   logic [15:0] l4_start;
   logic [15:0] k_full;
   logic        in_l4;
   logic [3:0]  k;

   assign req_chan.ready = !q_full;
   assign accept   = req_chan.valid && !q_full;
   assign b        = req_chan.frame_byte;
   assign ihl      = version_ihl_ff[3:0];
   assign l4_start = EthHdrBytes + {10'd0, ihl, 2'b00};
   assign k_full   = pos_ff - l4_start;
   assign in_l4    = (ihl >= IhlMin) && (pos_ff >= l4_start) && (k_full < L4CaptureSpan);
   assign k        = k_full[3:0];

   always_comb begin
      pos_in         = pos_ff;
      ether_type_in  = ether_type_ff;
      version_ihl_in = version_ihl_ff;
      total_len_in   = total_len_ff;
      frag_in        = frag_ff;
      ttl_in         = ttl_ff;
      proto_in       = proto_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      ports_in       = ports_ff;
      l4_word_in     = l4_word_ff;

      if (accept) begin
         if (pos_ff == 16'd12 || pos_ff == 16'd13) begin
            ether_type_in = {ether_type_ff[7:0], b};
         end else if (pos_ff == 16'd14) begin
            version_ihl_in = b;
         end else if (pos_ff == 16'd16 || pos_ff == 16'd17) begin
            total_len_in = {total_len_ff[7:0], b};
         end else if (pos_ff == 16'd20 || pos_ff == 16'd21) begin
            frag_in = {frag_ff[7:0], b};
         end else if (pos_ff == 16'd22) begin
            ttl_in = b;
         end else if (pos_ff == 16'd23) begin
            proto_in = b;
         end else if (pos_ff >= 16'd26 && pos_ff <= 16'd29) begin
            src_in = {src_ff[23:0], b};
         end else if (pos_ff >= 16'd30 && pos_ff <= 16'd33) begin
            dst_in = {dst_ff[23:0], b};
         end

         if (in_l4) begin
            if (k < 4'd4) begin
               ports_in = {ports_ff[23:0], b};
            end else if ((k == 4'd4 || k == 4'd5) && proto_ff == ProtoUdp) begin
               l4_word_in = {l4_word_ff[7:0], b};
            end else if ((k == 4'd12 || k == 4'd13) && proto_ff == ProtoTcp) begin
               l4_word_in = {l4_word_ff[7:0], b};
            end
         end

         if (pos_ff != PosMax) begin
            pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_comb begin
      push.valid                = accept && req_chan.last_byte;
      push.snap.frame_length    = pos_in;
      push.snap.ether_type      = ether_type_in;
      push.snap.version_ihl     = version_ihl_in;
      push.snap.ip_total_length = total_len_in;
      push.snap.fragment_word   = frag_in;
      push.snap.time_to_live    = ttl_in;
      push.snap.protocol        = proto_in;
      push.snap.source          = src_in;
      push.snap.dest            = dst_in;
      push.snap.ports           = ports_in;
      push.snap.l4_word         = l4_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push.valid) begin
         pos_ff         <= '0;
         ether_type_ff  <= '0;
         version_ihl_ff <= '0;
         total_len_ff   <= '0;
         frag_ff        <= '0;
         ttl_ff         <= '0;
         proto_ff       <= '0;
         src_ff         <= '0;
         dst_ff         <= '0;
         ports_ff       <= '0;
         l4_word_ff     <= '0;
      end else begin
         pos_ff         <= pos_in;
         ether_type_ff  <= ether_type_in;
         version_ihl_ff <= version_ihl_in;
         total_len_ff   <= total_len_in;
         frag_ff        <= frag_in;
         ttl_ff         <= ttl_in;
         proto_ff       <= proto_in;
         src_ff         <= src_in;
         dst_ff         <= dst_in;
         ports_ff       <= ports_in;
         l4_word_ff     <= l4_word_in;
      end
   end

endmodule

// ===== rtl/iphp_queue.sv =====
// ----------------------------------------------------------------------------
// iphp_queue
// Small FIFO of frame snapshots between the front end and the back end.
// ----------------------------------------------------------------------------
module iphp_queue #(
   parameter int Depth = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  iphp_pkg::snap_xfer_type push,
   input  logic                    pop,
   output iphp_pkg::snap_xfer_type head,
   output logic                    full
);
   import iphp_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   frame_snap_type  slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head.valid = (count_ff != '0);
   assign head.snap  = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.snap;
      end
   end

endmodule

// ===== rtl/iphp_back.sv =====
// ----------------------------------------------------------------------------
// iphp_back
// Verdict and field extraction for one queued frame, control registers and
// the registered result stage.
// ----------------------------------------------------------------------------
module iphp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  iphp_pkg::snap_xfer_type head,
   output logic                    pop,
   iphp_rsp_if.source              rsp_chan,
   iphp_csr_if.sink                csr_chan
);
   import iphp_pkg::*;

   logic        tcp_en_ff;
   logic        udp_en_ff;
   logic        frag_en_ff;

   logic        rsp_valid_ff;
   verdict_type verdict_ff, verdict_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;
   logic [7:0]  proto_ff, proto_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] payload_ff, payload_in;
   logic [15:0] len_ff, len_in;

   frame_snap_type s;
   logic [3:0]     ihl;
   logic [15:0]    hdr;
   logic [15:0]    need;
   logic           is_tcp;
   logic           is_udp;
   logic           unparsed;
   logic [15:0]    ip_payload;
   logic [3:0]     doff;
   logic [15:0]    l4_ports_src;
   logic [15:0]    l4_ports_dst;

   assign s            = head.snap;
   assign ihl          = s.version_ihl[3:0];
   assign hdr          = {10'd0, ihl, 2'b00};
   assign is_tcp       = (s.protocol == ProtoTcp);
   assign is_udp       = (s.protocol == ProtoUdp);
   assign doff         = s.l4_word[15:12];
   assign ip_payload   = s.ip_total_length - hdr;
   assign l4_ports_src = s.ports[31:16];
   assign l4_ports_dst = s.ports[15:0];

   always_comb begin
      need = EthHdrBytes + hdr;
      if (is_tcp) begin
         need = EthHdrBytes + hdr + 16'd20;
      end else if (is_udp || s.protocol == ProtoIcmp) begin
         need = EthHdrBytes + hdr + 16'd8;
      end
   end

   assign unparsed = (s.ether_type != EtherTypeIpv4) || (s.frame_length < IpMinEnd)
                   || (ihl < IhlMin) || (s.frame_length < need);

   always_comb begin
      verdict_in = VerdictPassRaw;
      src_in     = '0;
      dst_in     = '0;
      sport_in   = '0;
      dport_in   = '0;
      proto_in   = '0;
      flags_in   = '0;
      payload_in = '0;
      len_in     = s.frame_length;
      if (!unparsed) begin
         src_in     = s.source;
         dst_in     = s.dest;
         proto_in   = s.protocol;
         payload_in = ip_payload;
         if (is_tcp) begin
            sport_in   = l4_ports_src;
            dport_in   = l4_ports_dst;
            flags_in   = s.l4_word[7:0];
            payload_in = ip_payload - {10'd0, doff, 2'b00};
         end else if (is_udp) begin
            sport_in   = l4_ports_src;
            dport_in   = l4_ports_dst;
            payload_in = s.l4_word - 16'd8;
         end

         if ((s.version_ihl[7:4] != IpVersion4) || (s.ip_total_length < hdr)
             || (s.time_to_live == 8'd0)) begin
            verdict_in = VerdictDropMalformed;
         end else if (tcp_en_ff && is_tcp && ((doff < IhlMin)
                      || (l4_ports_src == 16'd0) || (l4_ports_dst == 16'd0))) begin
            verdict_in = VerdictDropMalformed;
         end else if (udp_en_ff && is_udp && ((s.l4_word < 16'd8)
                      || (l4_ports_src == 16'd0))) begin
            verdict_in = VerdictDropMalformed;
         end else if (frag_en_ff && ((s.fragment_word[13:0] & FragMask) != 14'd0)) begin
            verdict_in = VerdictDropFragment;
         end else begin
            verdict_in = VerdictPassValid;
         end
      end
   end

   assign pop = head.valid && (!rsp_valid_ff || rsp_chan.ready);

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_en_ff  <= 1'b0;
         udp_en_ff  <= 1'b0;
         frag_en_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CsrTcpCheck: tcp_en_ff  <= csr_chan.data;
            CsrUdpCheck: udp_en_ff  <= csr_chan.data;
            CsrFragDrop: frag_en_ff <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         verdict_ff <= verdict_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         sport_ff   <= sport_in;
         dport_ff   <= dport_in;
         proto_ff   <= proto_in;
         flags_ff   <= flags_in;
         payload_ff <= payload_in;
         len_ff     <= len_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.verdict         = verdict_ff;
   assign rsp_chan.source_address  = src_ff;
   assign rsp_chan.dest_address    = dst_ff;
   assign rsp_chan.source_port     = sport_ff;
   assign rsp_chan.dest_port       = dport_ff;
   assign rsp_chan.protocol_number = proto_ff;
   assign rsp_chan.tcp_flag_bits   = flags_ff;
   assign rsp_chan.payload_length  = payload_ff;
   assign rsp_chan.frame_length    = len_ff;

endmodule
